>>> rtl/czfr_pkg.sv
// ============================================================================
// czfr_pkg
// Shared widths, register indexes and types for the centre zoom / fisheye
// coordinate remap unit.
// ============================================================================
`default_nettype none

package czfr_pkg;

    localparam int COORD_W   = 12;   // pixel coordinate
    localparam int DIM_W     = 13;   // frame dimension register
    localparam int FACT_W    = 24;   // zoom, base and slope registers
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int TDATA_W   = 24;

    localparam int DIM_REG_MAX = (1 << DIM_W) - 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WARP_MODE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZOOM_FACTOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_FACTOR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR_SLOPE = 3'd5;

    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 13'd480;
    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 13'd640;
    localparam logic              RST_WARP_MODE    = 1'b1;
    localparam logic [FACT_W-1:0] RST_ZOOM_FACTOR  = 24'd32768;
    localparam logic [FACT_W-1:0] RST_BASE_FACTOR  = 24'd6554;
    localparam logic [FACT_W-1:0] RST_FACTOR_SLOPE = 24'd83886;

    localparam logic MODE_ZOOM    = 1'b0;
    localparam logic MODE_FISHEYE = 1'b1;

    // squared radius and its square root (8 fraction bits)
    localparam int SQR_W     = 2 * COORD_W;          // one squared offset
    localparam int SUM_W     = SQR_W + 1;            // sum of both
    localparam int SUM_PAIRS = (SUM_W + 1) / 2;      // bit pairs taken from the sum
    localparam int SQ_STAGES = SUM_PAIRS + 8;        // 16 zero fraction bits: 8 pairs
    localparam int ROOT_W    = SQ_STAGES;
    localparam int REM_W     = ROOT_W + 2;

    // scale factor, Q.32
    localparam int SLP_W  = FACT_W + ROOT_W;         // slope * distance
    localparam int FAC_W  = SLP_W + 1;
    localparam int FLO_W  = FAC_W / 2;
    localparam int FHI_W  = FAC_W - FLO_W;
    localparam int PP_W   = COORD_W + FHI_W;
    localparam int PROD_W = COORD_W + FAC_W;
    localparam int V_W    = PROD_W + 2;
    localparam int INT_W  = V_W - 33;                // integer part of a positive value

    localparam int LAT    = SQ_STAGES + 9;           // register stages, input to output

    typedef struct packed {
        logic                neg_y;
        logic                neg_x;
        logic [COORD_W-1:0]  mag_y;
        logic [COORD_W-1:0]  mag_x;
    } czfr_off_t;

endpackage

`default_nettype wire

>>> rtl/center_zoom_fisheye_remap_unit.sv
// ============================================================================
// center_zoom_fisheye_remap_unit
// Inverse warp about the frame centre: maps a destination pixel to its source
// pixel by a constant zoom or a radial fisheye factor, with a range flag.
// ============================================================================
//  channel | dir | handshake          | contents
//  s_      | in  | s_tvalid/s_tready  | tdata: out_row, out_col
//  m_      | out | m_tvalid/m_tready  | tdata: src_row, src_col; tuser: in_range
//  cfg_    | in  | cfg_wr_en          | cfg_index, cfg_data
//
//  One item per cycle unless the output stalls. LAT register stages: the 21 root
//  stages (one root bit each), offset, square, sum, factor, multiply, add, output.
//  Reset clears the stage valid bits, the skid entry and the registers to
//  their defaults. A stall freezes every stage; an item arriving in the stall
//  cycle is held in a one-entry skid register, so s_tready is registered.
`default_nettype none

module center_zoom_fisheye_remap_unit
    import czfr_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [TDATA_W-1:0]    s_tdata,   // [11:0] out_row, [23:12] out_col
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [TDATA_W-1:0]         m_tdata,   // [11:0] src_row, [23:12] src_col
    output logic                       m_tuser,   // [0] in_range
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  cfg_data
);

    localparam int DIM_CAP = (MAX_DIM > DIM_REG_MAX) ? DIM_REG_MAX : MAX_DIM;

    // configuration
    logic [DIM_W-1:0]   frame_height_reg;
    logic [DIM_W-1:0]   frame_width_reg;
    logic               warp_mode_reg;
    logic [FACT_W-1:0]  zoom_factor_reg;
    logic [FACT_W-1:0]  base_factor_reg;
    logic [FACT_W-1:0]  factor_slope_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_height_reg <= RST_FRAME_HEIGHT;
            frame_width_reg  <= RST_FRAME_WIDTH;
            warp_mode_reg    <= RST_WARP_MODE;
            zoom_factor_reg  <= RST_ZOOM_FACTOR;
            base_factor_reg  <= RST_BASE_FACTOR;
            factor_slope_reg <= RST_FACTOR_SLOPE;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_W-1:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_W-1:0];
                REG_WARP_MODE:    warp_mode_reg    <= cfg_data[0];
                REG_ZOOM_FACTOR:  zoom_factor_reg  <= cfg_data[FACT_W-1:0];
                REG_BASE_FACTOR:  base_factor_reg  <= cfg_data[FACT_W-1:0];
                REG_FACTOR_SLOPE: factor_slope_reg <= cfg_data[FACT_W-1:0];
                default:          ;
            endcase
        end
    end

    logic [DIM_W-1:0]   dim_h;
    logic [DIM_W-1:0]   dim_w;
    logic [COORD_W-1:0] half_h;
    logic [COORD_W-1:0] half_w;

    assign dim_h  = (frame_height_reg > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : frame_height_reg;
    assign dim_w  = (frame_width_reg  > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : frame_width_reg;
    assign half_h = dim_h[DIM_W-1:1];
    assign half_w = dim_w[DIM_W-1:1];

    // stall control and input skid
    logic                 ce;
    logic [LAT-1:0]       vld_reg;
    logic [LAT-1:0]       vld_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    logic [TDATA_W-1:0]   skid_data_reg;
    logic                 in_acc;
    logic                 pipe_in_valid;
    logic [TDATA_W-1:0]   pipe_in_data;

    assign ce            = !vld_reg[LAT-1] || m_tready;
    assign s_tready      = !skid_valid_reg;
    assign in_acc        = s_tvalid && s_tready;
    assign pipe_in_valid = skid_valid_reg || in_acc;
    assign pipe_in_data  = skid_valid_reg ? skid_data_reg : s_tdata;

    assign skid_valid_next = ce ? 1'b0 : (skid_valid_reg || in_acc);
    assign vld_next        = {vld_reg[LAT-2:0], pipe_in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
            vld_reg        <= '0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
            if (ce)
            begin
                vld_reg <= vld_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && !ce)
        begin
            skid_data_reg <= s_tdata;
        end
    end

    // stage 1: offsets from the centre as sign and magnitude
    logic [COORD_W:0]   dy;
    logic [COORD_W:0]   dx;
    czfr_off_t          off_next;
    czfr_off_t          p1_off_reg;

    assign dy = {1'b0, pipe_in_data[COORD_W-1:0]} - {1'b0, half_h};
    assign dx = {1'b0, pipe_in_data[2*COORD_W-1:COORD_W]} - {1'b0, half_w};

    always_comb
    begin
        logic [COORD_W:0] ny;
        logic [COORD_W:0] nx;
        ny             = -dy;
        nx             = -dx;
        off_next.neg_y = dy[COORD_W];
        off_next.neg_x = dx[COORD_W];
        off_next.mag_y = dy[COORD_W] ? ny[COORD_W-1:0] : dy[COORD_W-1:0];
        off_next.mag_x = dx[COORD_W] ? nx[COORD_W-1:0] : dx[COORD_W-1:0];
    end

    // stage 2: squares, stage 3: squared radius
    logic [SQR_W-1:0]   p2_sqy_reg;
    logic [SQR_W-1:0]   p2_sqx_reg;
    czfr_off_t          p2_off_reg;
    logic [SUM_W-1:0]   p3_sum_reg;
    czfr_off_t          p3_off_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p1_off_reg <= off_next;
            p2_sqy_reg <= p1_off_reg.mag_y * p1_off_reg.mag_y;
            p2_sqx_reg <= p1_off_reg.mag_x * p1_off_reg.mag_x;
            p2_off_reg <= p1_off_reg;
            p3_sum_reg <= {1'b0, p2_sqy_reg} + {1'b0, p2_sqx_reg};
            p3_off_reg <= p2_off_reg;
        end
    end

    // square root of sum * 2^16, one root bit per stage
    logic [SUM_W-1:0]   sq_sum_reg  [SUM_PAIRS-1];
    logic [REM_W-1:0]   sq_rem_reg  [SQ_STAGES-1];
    logic [ROOT_W-1:0]  sq_root_reg [SQ_STAGES];
    czfr_off_t          sq_off_reg  [SQ_STAGES];

    genvar k;
    generate
        for (k = 0; k < SQ_STAGES; k++)
        begin : g_sq
            logic [REM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            czfr_off_t         off_in;
            logic [1:0]        pair;
            logic [REM_W-1:0]  rem_sh;
            logic [REM_W-1:0]  trial;
            logic              take;

            if (k == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign off_in  = p3_off_reg;
            end
            else
            begin : g_next
                assign rem_in  = sq_rem_reg[k-1];
                assign root_in = sq_root_reg[k-1];
                assign off_in  = sq_off_reg[k-1];
            end

            if (k < SUM_PAIRS)
            begin : g_pair
                logic [SUM_W-1:0] sum_in;
                logic [2*SUM_PAIRS-1:0] sum_pad;
                if (k == 0)
                begin : g_s0
                    assign sum_in = p3_sum_reg;
                end
                else
                begin : g_sn
                    assign sum_in = sq_sum_reg[k-1];
                end
                assign sum_pad = (2*SUM_PAIRS)'(sum_in);
                assign pair    = sum_pad[2*SUM_PAIRS-1-2*k -: 2];
                if (k < SUM_PAIRS - 1)
                begin : g_keep
                    always_ff @(posedge clk)
                    begin
                        if (ce)
                        begin
                            sq_sum_reg[k] <= sum_in;
                        end
                    end
                end
            end
            else
            begin : g_zero
                assign pair = 2'b00;
            end

            assign rem_sh = {rem_in[REM_W-3:0], pair};
            assign trial  = {root_in, 2'b01};
            assign take   = rem_sh >= trial;

            if (k < SQ_STAGES - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (ce)
                    begin
                        sq_rem_reg[k] <= take ? (rem_sh - trial) : rem_sh;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    sq_root_reg[k] <= {root_in[ROOT_W-2:0], take};
                    sq_off_reg[k]  <= off_in;
                end
            end
        end
    endgenerate

    // factor: slope * distance, then add base or take the zoom
    logic [SLP_W-1:0]   p5_slp_reg;
    czfr_off_t          p5_off_reg;
    logic [FAC_W-1:0]   p6_fac_reg;
    czfr_off_t          p6_off_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p5_slp_reg <= {{ROOT_W{1'b0}}, factor_slope_reg}
                          * {{FACT_W{1'b0}}, sq_root_reg[SQ_STAGES-1]};
            p5_off_reg <= sq_off_reg[SQ_STAGES-1];
            if (warp_mode_reg == MODE_FISHEYE)
            begin
                p6_fac_reg <= {1'b0, p5_slp_reg}
                              + FAC_W'({base_factor_reg, 16'b0});
            end
            else
            begin
                p6_fac_reg <= FAC_W'({zoom_factor_reg, 16'b0});
            end
            p6_off_reg <= p5_off_reg;
        end
    end

    // offset * factor in two partial products per axis
    logic [PP_W-1:0]    p7_ylo_reg;
    logic [PP_W-1:0]    p7_yhi_reg;
    logic [PP_W-1:0]    p7_xlo_reg;
    logic [PP_W-1:0]    p7_xhi_reg;
    logic [1:0]         p7_neg_reg;
    logic [PROD_W-1:0]  p8_py_reg;
    logic [PROD_W-1:0]  p8_px_reg;
    logic [1:0]         p8_neg_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p7_ylo_reg <= PP_W'(p6_off_reg.mag_y) * PP_W'(p6_fac_reg[FLO_W-1:0]);
            p7_yhi_reg <= PP_W'(p6_off_reg.mag_y) * PP_W'(p6_fac_reg[FAC_W-1:FLO_W]);
            p7_xlo_reg <= PP_W'(p6_off_reg.mag_x) * PP_W'(p6_fac_reg[FLO_W-1:0]);
            p7_xhi_reg <= PP_W'(p6_off_reg.mag_x) * PP_W'(p6_fac_reg[FAC_W-1:FLO_W]);
            p7_neg_reg <= {p6_off_reg.neg_y, p6_off_reg.neg_x};
            p8_py_reg  <= PROD_W'(p7_ylo_reg) + {p7_yhi_reg, {FLO_W{1'b0}}};
            p8_px_reg  <= PROD_W'(p7_xlo_reg) + {p7_xhi_reg, {FLO_W{1'b0}}};
            p8_neg_reg <= p7_neg_reg;
        end
    end

    // centre plus or minus the scaled offset, Q.32 two's complement
    logic [V_W-1:0]     base_y;
    logic [V_W-1:0]     base_x;
    logic [V_W-1:0]     p9_vy_reg;
    logic [V_W-1:0]     p9_vx_reg;

    assign base_y = V_W'({half_h, 32'b0});
    assign base_x = V_W'({half_w, 32'b0});

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p9_vy_reg <= p8_neg_reg[1] ? (base_y - V_W'(p8_py_reg))
                                       : (base_y + V_W'(p8_py_reg));
            p9_vx_reg <= p8_neg_reg[0] ? (base_x - V_W'(p8_px_reg))
                                       : (base_x + V_W'(p8_px_reg));
        end
    end

    // truncate toward zero and check the frame bounds
    logic [INT_W-1:0]   int_y;
    logic [INT_W-1:0]   int_x;
    logic               ok_y;
    logic               ok_x;
    logic               ok;
    logic [COORD_W-1:0] out_row_reg;
    logic [COORD_W-1:0] out_col_reg;
    logic               out_ok_reg;

    assign int_y = p9_vy_reg[V_W-2:32];
    assign int_x = p9_vx_reg[V_W-2:32];

    // a value in (-1, 0) truncates to coordinate 0
    assign ok_y = p9_vy_reg[V_W-1] ? ((&p9_vy_reg[V_W-1:32]) && (|p9_vy_reg[31:0])
                                      && (dim_h != '0))
                                   : (int_y < INT_W'(dim_h));
    assign ok_x = p9_vx_reg[V_W-1] ? ((&p9_vx_reg[V_W-1:32]) && (|p9_vx_reg[31:0])
                                      && (dim_w != '0))
                                   : (int_x < INT_W'(dim_w));
    assign ok   = ok_y && ok_x;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_row_reg <= (ok && !p9_vy_reg[V_W-1]) ? int_y[COORD_W-1:0] : '0;
            out_col_reg <= (ok && !p9_vx_reg[V_W-1]) ? int_x[COORD_W-1:0] : '0;
            out_ok_reg  <= ok;
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = {out_col_reg, out_row_reg};
    assign m_tuser  = out_ok_reg;

endmodule

`default_nettype wire

>>> rtl/czfr_checker.sv
// ============================================================================
// czfr_checker
// Port-level checks for the remap unit, bound to the top level.
// ============================================================================
`default_nettype none

module czfr_checker
    import czfr_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [TDATA_W-1:0]  m_tdata,
    input wire logic                m_tuser
);

    // out-of-range items carry a zero coordinate pair
    a_zero_when_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("out-of-range item with nonzero coordinates");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // skid fills only on an accepted item
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("input ready dropped without an item");

    // a full skid drains as soon as the output moves
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready && m_tready |=> s_tready)
        else $error("skid entry not drained");

endmodule

bind center_zoom_fisheye_remap_unit czfr_checker u_czfr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
